// ===== sv/indexed_sequence_store_defines.svh =====
// Assertion macros used by the verification file of the sequence store.
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define ISQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Payload must hold while a transaction is stalled.
`define ISQ_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
    `ISQ_ASSERT(lbl, clk, rstn, (vld && !rdy) |=> $stable(sig), msg)

`endif

// ===== sv/isq_pkg.sv =====
// ----------------------------------------------------------------------------
// isq_pkg
// Types and codes for the indexed sequence store.
// ----------------------------------------------------------------------------
package isq_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd6;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } isq_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
        logic [STATUS_W-1:0]      status;
    } isq_out_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic              insert_en;
        logic              erase_en;
        logic [WORD_W-1:0] value;
    } isq_ctrl_t;

endpackage

// ===== sv/isq_cell.sv =====
// ----------------------------------------------------------------------------
// isq_cell
// One storage cell of the chain: holds the word at a fixed index and takes
// its lower or upper neighbor's word when the sequence shifts.
// ----------------------------------------------------------------------------
module isq_cell #(
    parameter int IDX   = 0,
    parameter int CMP_W = 7
) (
    input  logic                       aclk,
    input  isq_pkg::isq_ctrl_t         ctrl,
    input  logic [CMP_W-1:0]           target,
    input  logic [isq_pkg::WORD_W-1:0] prev_word,
    input  logic [isq_pkg::WORD_W-1:0] next_word,
    output logic [isq_pkg::WORD_W-1:0] word,
    output logic [isq_pkg::WORD_W-1:0] sel_word
);
    import isq_pkg::*;

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        if (ctrl.insert_en) begin
            if (MY_IDX == target) begin
                word_next = ctrl.value;
            end else if (MY_IDX > target) begin
                word_next = prev_word;
            end
        end else if (ctrl.erase_en) begin
            if (MY_IDX >= target) begin
                word_next = next_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign sel_word = (MY_IDX == target) ? word_reg : '0;

endmodule

// ===== sv/indexed_sequence_store.sv =====
// A command's result is registered in the cycle after its transaction.
// Throughput: one command per cycle when not stalled; every cell shifts in
//   parallel; a read is an AND-OR gather of the cell chain into m_data_reg.
// s_ready is high whenever the output register is empty or being drained.
// Reset clears the word count and output valid; cell contents stay undefined
//   until written.
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Deque with indexed insert, erase and read, built as a chain of word cells.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
    parameter int CAPACITY = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  isq_pkg::isq_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output isq_pkg::isq_out_t m_data
);
    import isq_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;
    logic              m_valid_reg;
    isq_out_t          m_data_reg;

    isq_ctrl_t         ctrl;
    logic [CMP_W-1:0]  target;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  len_x;
    logic              full;
    logic              empty;
    logic              accept;
    logic              rd_en;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0] gather;

    logic [WORD_W-1:0] cell_word [CAPACITY];
    logic [WORD_W-1:0] cell_sel  [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign pos_x   = CMP_W'(s_data.position);
    assign len_x   = CMP_W'(length_reg);
    assign full    = (length_reg == LEN_W'(CAPACITY));
    assign empty   = (length_reg == '0);

    always_comb begin
        length_next    = length_reg;
        ctrl.insert_en = 1'b0;
        ctrl.erase_en  = 1'b0;
        ctrl.value     = s_data.value;
        target         = pos_x;
        rd_en          = 1'b0;
        status         = ST_DONE;
        case (s_data.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                target = (s_data.cmd == CMD_PUSH_FRONT) ? '0 : len_x;
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.insert_en = 1'b1;
                    length_next    = length_reg + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                target = '0;
                if (empty) begin
                    status = ST_RANGE;
                end else begin
                    ctrl.erase_en = (s_data.cmd == CMD_POP_FRONT);
                    length_next   = length_reg - 1'b1;
                end
            end
            CMD_INSERT: begin
                if (pos_x > len_x) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.insert_en = 1'b1;
                    length_next    = length_reg + 1'b1;
                end
            end
            CMD_ERASE: begin
                if (pos_x >= len_x) begin
                    status = ST_RANGE;
                end else begin
                    ctrl.erase_en = 1'b1;
                    length_next   = length_reg - 1'b1;
                end
            end
            CMD_READ: begin
                if (pos_x >= len_x) begin
                    status = ST_RANGE;
                end else begin
                    rd_en = 1'b1;
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
        if (!accept) begin
            ctrl.insert_en = 1'b0;
            ctrl.erase_en  = 1'b0;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_W-1:0] prev_w;
        logic [WORD_W-1:0] next_w;
        if (i == 0) begin : g_first
            assign prev_w = '0;
        end else begin : g_prev
            assign prev_w = cell_word[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign next_w = '0;
        end else begin : g_next
            assign next_w = cell_word[i+1];
        end
        isq_cell #(
            .IDX   (i),
            .CMP_W (CMP_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .target    (target),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (cell_word[i]),
            .sel_word  (cell_sel[i])
        );
    end

    // At most one cell matches the target, so OR gathers its word.
    always_comb begin
        gather = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            gather = gather | cell_sel[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                length_reg  <= length_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_data_reg.read_value <= rd_en ? gather : '0;
            m_data_reg.count      <= COUNT_W'(length_next);
            m_data_reg.status     <= status;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/isq_checker.sv =====
// ----------------------------------------------------------------------------
// isq_checker
// Port-level checks on the indexed sequence store, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_sequence_store_defines.svh"

module isq_checker #(
    parameter int CAPACITY = 64
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input isq_pkg::isq_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input isq_pkg::isq_out_t m_data
);
    import isq_pkg::*;

    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

    // A stalled result transaction keeps its payload.
    `ISQ_ASSERT_HOLD(a_result_hold, aclk, aresetn, m_valid, m_ready, m_data, "result changed while stalled")
    // The output stage never blocks input while it is empty.
    `ISQ_ASSERT(a_ready_when_empty, aclk, aresetn, !m_valid |-> s_ready, "input stalled with empty output")
    // A full status only appears with the store at capacity.
    `ISQ_ASSERT(a_full_count, aclk, aresetn, (m_valid && m_data.status == ST_FULL) |-> (m_data.count == CAP_COUNT), "full status below capacity")
    // Read data is zero unless the command succeeded.
    `ISQ_ASSERT(a_read_zero, aclk, aresetn, (m_valid && m_data.status != ST_DONE) |-> (m_data.read_value == '0), "read data on failed command")
    // An accepted command always produces a result in the next cycle.
    `ISQ_ASSERT(a_result_follows, aclk, aresetn, (s_valid && s_ready) |=> m_valid, "no result after accepted command")

endmodule

bind indexed_sequence_store isq_checker #(
    .CAPACITY (CAPACITY)
) u_isq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
